### sv/rasch_pkg.sv
// ----------------------------------------------------------------------------
// rasch_pkg: shared types and constants for the room allocation scheduler
// Room count, index widths, payload structs and the scan record that walks
// the row of room cells.
// ----------------------------------------------------------------------------
package rasch_pkg;

	// Number of room cells built into the row
	localparam int ROOMS = 16;
	// Bits of a room index inside the design
	localparam int ROOM_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
	// Width of the configured room count
	localparam int NUM_W = 5;
	// Common width for comparing a room index with the configured count
	localparam int CMP_W = ((ROOM_W > NUM_W) ? ROOM_W : NUM_W) + 1;
	// Width of a room index on the result fields
	localparam int FIELD_W = 4;
	// Room count after reset
	localparam logic [NUM_W-1:0] NUM_ROOMS_RST = NUM_W'(16);

	typedef logic [ROOM_W-1:0] room_idx_t;

	// Input transaction payload
	typedef struct packed {
		logic [31:0] start_time;
		logic [31:0] end_time;
	} in_t;

	// Result transaction payload
	typedef struct packed {
		logic [FIELD_W-1:0] assigned_room;
		logic [31:0]        finish_time;
		logic [FIELD_W-1:0] most_booked_room;
	} out_t;

	// Record handed from cell to cell while one booking is placed
	typedef struct packed {
		logic        vld;
		logic [31:0] start;
		logic [31:0] len;
		logic        found;      // a free room has been taken
		room_idx_t   room;       // chosen room so far
		logic [31:0] room_fin;   // its finish time
		logic [31:0] room_uses;  // its use count
		room_idx_t   best;       // most used room so far (before update)
		logic [31:0] best_uses;
	} scan_t;

	// Write-back to the chosen cell
	typedef struct packed {
		logic        we;
		room_idx_t   idx;
		logic [31:0] finish;
		logic [31:0] uses;
	} upd_t;

	// Room index masked or extended to the result field width
	function automatic logic [FIELD_W-1:0] to_field(input room_idx_t idx);
		logic [ROOM_W+FIELD_W-1:0] ext;
		ext = {{FIELD_W{1'b0}}, idx};
		return ext[FIELD_W-1:0];
	endfunction

endpackage

### sv/rasch_cell.sv
// ----------------------------------------------------------------------------
// rasch_cell: one room of the scheduler row
// Holds the room's finish time and use count, folds them into the passing
// scan record and registers it towards the next cell.
// ----------------------------------------------------------------------------
module rasch_cell
	import rasch_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  room_idx_t        idx,
	input  logic [NUM_W-1:0] num_rooms,
	input  scan_t            rec_in,
	input  upd_t             upd,
	output scan_t            rec_out
);

	logic [31:0] finish_q;
	logic [31:0] uses_q;
	scan_t       rec_q;
	scan_t       rec_d;
	logic        first;
	logic        active;
	logic        free;
	logic        take;

	// Room takes part when below the count; room 0 always does
	assign first  = (idx == '0);
	assign active = first || (CMP_W'(idx) < CMP_W'(num_rooms));
	assign free   = finish_q <= rec_in.start;
	assign take   = active && !rec_in.found && (free || first || finish_q < rec_in.room_fin);

	// Fold this room into the record
	always_comb begin
		rec_d = rec_in;
		if (take) begin
			rec_d.found     = free;
			rec_d.room      = idx;
			rec_d.room_fin  = finish_q;
			rec_d.room_uses = uses_q;
		end
		if (active && (first || uses_q > rec_in.best_uses)) begin
			rec_d.best      = idx;
			rec_d.best_uses = uses_q;
		end
	end

	// Room state, written back when this room is chosen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finish_q <= '0;
			uses_q   <= '0;
		end else if (upd.we && upd.idx == idx) begin
			finish_q <= upd.finish;
			uses_q   <= upd.uses;
		end
	end

	// Record stage towards the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= rec_d;
		end
	end

	assign rec_out = rec_q;

endmodule

### sv/rasch_resolve.sv
// ----------------------------------------------------------------------------
// rasch_resolve: closes one booking at the end of the row
// Works out the actual finish time, the new use count and the most used
// room, and builds the write-back for the chosen cell.
// ----------------------------------------------------------------------------
module rasch_resolve
	import rasch_pkg::*;
(
	input  scan_t rec,
	output upd_t  upd,
	output out_t  res
);

	logic [31:0] base;
	logic [32:0] sum;
	logic [31:0] finish;
	logic [31:0] uses_new;
	logic        win;

	// Delayed bookings start at the room's finish time; saturate on overflow
	assign base   = rec.found ? rec.start : rec.room_fin;
	assign sum    = {1'b0, base} + {1'b0, rec.len};
	assign finish = sum[32] ? '1 : sum[31:0];

	// Saturating use count
	assign uses_new = (&rec.room_uses) ? rec.room_uses : rec.room_uses + 32'd1;

	// Chosen room overtakes the previous leader, lower index on ties
	assign win = (uses_new > rec.best_uses) ||
		((uses_new == rec.best_uses) && (rec.room < rec.best));

	always_comb begin
		upd.we     = rec.vld;
		upd.idx    = rec.room;
		upd.finish = finish;
		upd.uses   = uses_new;
		res.assigned_room    = to_field(rec.room);
		res.finish_time      = finish;
		res.most_booked_room = to_field(win ? rec.room : rec.best);
	end

endmodule

### sv/room_allocation_scheduler_top.sv
// ----------------------------------------------------------------------------
// room_allocation_scheduler_top: meeting room allocator on a row of cells
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_data   (in_t)
//   out     | output    | out_valid/ out_ready | out_data  (out_t)
//   cfg     | input     | cfg_valid/ cfg_ready | cfg_data  (room count)
//
// One booking is in the row at a time: it walks ROOMS cells, one a cycle,
// and the chosen room is written back as the result is registered; the
// next booking is taken only once the previous one has left the row.
// A result register plus one spare stage hold finished transactions; a new
// booking is taken while the result register waits, unless the spare is full.
// Reset clears all room state, sets the room count to 16 and empties the row.
// ----------------------------------------------------------------------------
module room_allocation_scheduler_top
	import rasch_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [NUM_W-1:0] cfg_data
);

	logic [NUM_W-1:0] num_rooms_q;
	logic             busy_q;
	logic             pend_valid_q;
	out_t             pend_q;
	logic             out_valid_q;
	out_t             out_q;
	scan_t            launch;
	scan_t            chain [ROOMS+1];
	upd_t             upd;
	out_t             res;
	logic             in_fire;
	logic             done;
	logic             out_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q && !pend_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign done      = chain[ROOMS].vld;

	// Room count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rooms_q <= NUM_ROOMS_RST;
		end else if (cfg_valid && cfg_ready) begin
			num_rooms_q <= cfg_data;
		end
	end

	// Launch record for the first cell
	always_comb begin
		launch.vld       = in_fire;
		launch.start     = in_data.start_time;
		launch.len       = (in_data.end_time > in_data.start_time) ?
			(in_data.end_time - in_data.start_time) : '0;
		launch.found     = 1'b0;
		launch.room      = '0;
		launch.room_fin  = '0;
		launch.room_uses = '0;
		launch.best      = '0;
		launch.best_uses = '0;
	end

	assign chain[0] = launch;

	// Row of room cells
	for (genvar i = 0; i < ROOMS; i++) begin : g_cell
		rasch_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (ROOM_W'(i)),
			.num_rooms (num_rooms_q),
			.rec_in    (chain[i]),
			.upd       (upd),
			.rec_out   (chain[i+1])
		);
	end

	rasch_resolve u_resolve (
		.rec (chain[ROOMS]),
		.upd (upd),
		.res (res)
	);

	// Booking in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_fire) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// Result register and spare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (done) begin
				if (!out_valid_q || out_fire) begin
					out_valid_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				out_valid_q  <= pend_valid_q;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (!out_valid_q || out_fire) begin
				out_q <= res;
			end else begin
				pend_q <= res;
			end
		end else if (out_fire && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
